>>> rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared word types, operation and status codes, controller states and the
// command and status groups that pass between the controller and datapath.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Operation codes carried in the func field.
  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  // The home slot is found by a reciprocal multiplication: the quotient
  // estimate first, then the remainder and its correction.
  localparam int HASH_W     = 32;
  localparam int HASH_STEPS = 2;
  localparam int STEP_W     = $clog2(HASH_STEPS);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_KEY = 2'd1,
    ST_FULL     = 2'd2
  } lpht_status_t;

  // Input word.
  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic [31:0] value;
  } lpht_in_t;

  // Result word.
  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic [1:0]  status;
  } lpht_out_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_ISSUE,
    S_CHECK
  } lpht_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         clr_step;
    logic         load;
    logic         mod_step;
    logic         probe_start;
    logic         probe_next;
    logic         write_slot;
    logic         finish;
    lpht_status_t fin_status;
  } lpht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic key_zero;
    logic mod_last;
    logic clr_last;
    logic slot_hit;
    logic last_probe;
    logic is_put;
  } lpht_stat_t;

endpackage

>>> rtl/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// Linear probe hash table controller
// Sequences the clearing pass, the hash reduction, the probe walk and the
// slot write, and tells the datapath when to present a result.
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  lpht_pkg::lpht_stat_t stat,
  output lpht_pkg::lpht_cmd_t  cmd,
  output logic               busy
);
  import lpht_pkg::*;

  lpht_state_t state_r, state_nxt;

  // State register; reset starts the clearing pass of the key store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.fin_status = ST_OK;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (stat.key_zero) begin
            // A zero key is answered at once and touches nothing.
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_ZERO_KEY;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.probe_start = 1'b1;
        state_nxt       = S_CHECK;
      end
      S_CHECK: begin
        if (stat.slot_hit) begin
          // Empty slot or matching key ends the walk.
          cmd.write_slot = stat.is_put;
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_OK;
          state_nxt      = S_IDLE;
        end else if (stat.last_probe) begin
          // Every slot holds some other key.
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> rtl/lpht_datapath.sv
// ----------------------------------------------------------------------------
// Linear probe hash table datapath
// Holds the request, reduces the hash to a home slot, walks the key and value
// memories one slot a cycle and registers the result word.
// ----------------------------------------------------------------------------
module lpht_datapath #(
  parameter int TABLE_SIZE = 1024,
  parameter int KEY_WIDTH  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lpht_pkg::lpht_in_t   in_data,
  input  lpht_pkg::lpht_cmd_t  cmd,
  output lpht_pkg::lpht_stat_t stat,
  output logic                 out_valid,
  output lpht_pkg::lpht_out_t  out_data
);
  import lpht_pkg::*;

  localparam int IDXW = $clog2(TABLE_SIZE);
  localparam logic [IDXW:0]   SIZE_EXT = (IDXW + 1)'(TABLE_SIZE);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_SIZE - 1);
  localparam logic [HASH_W-1:0] RECIP  = HASH_W'((64'd1 << HASH_W) / TABLE_SIZE);

  // Key and value memories.
  logic [KEY_WIDTH-1:0] key_mem [TABLE_SIZE];
  logic [31:0]          val_mem [TABLE_SIZE];

  logic [KEY_WIDTH-1:0] key_in;
  logic [KEY_WIDTH-1:0] key_r;
  logic [31:0]          val_r;
  logic                 func_r;
  logic [HASH_W-1:0]    hash_r;
  logic [IDXW:0]        quot_r, quot_nxt;
  logic [IDXW:0]        rem_est;
  logic [IDXW-1:0]      rem_r, rem_nxt;
  logic [STEP_W-1:0]    step_r;
  logic [IDXW-1:0]      ptr_r, ptr_inc, rd_addr;
  logic [IDXW-1:0]      cnt_r;
  logic [KEY_WIDTH-1:0] rd_key_r;
  logic [31:0]          rd_val_r;
  logic                 wr_en;
  logic [KEY_WIDTH-1:0] wr_key;
  logic                 found_nxt;
  logic                 out_valid_r;
  lpht_out_t            out_data_r;

  // Bring the key word to the stored key width.
  generate
    if (KEY_WIDTH > 32) begin : g_key_wide
      assign key_in = {{(KEY_WIDTH - 32){1'b0}}, in_data.key};
    end else begin : g_key_narrow
      assign key_in = in_data.key[KEY_WIDTH-1:0];
    end
  endgenerate

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= key_in;
      val_r  <= in_data.value;
      func_r <= in_data.func;
    end
  end

  // Home slot by reciprocal multiplication. The quotient estimate is exact or
  // one short, so the remainder formed from its low bits is below twice the
  // table size and one compare and subtract corrects it.
  assign quot_nxt = (IDXW + 1)'((64'(hash_r) * 64'(RECIP)) >> HASH_W);
  assign rem_est  = hash_r[IDXW:0] - quot_r * SIZE_EXT;
  assign rem_nxt  = (rem_est >= SIZE_EXT) ? IDXW'(rem_est - SIZE_EXT) : IDXW'(rem_est);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hash_r <= in_data.key_hash;
      step_r <= '0;
    end else if (cmd.mod_step) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r + 1'b1;
    end
  end

  // Slot pointer with wrap; it also walks the memory during the clearing pass.
  assign ptr_inc = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;

  always_comb begin
    if (cmd.probe_start) begin
      rd_addr = rem_r;
    end else if (cmd.probe_next) begin
      rd_addr = ptr_inc;
    end else begin
      rd_addr = ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.clr_step || cmd.probe_next) begin
        ptr_r <= ptr_inc;
      end else if (cmd.probe_start) begin
        ptr_r <= rem_r;
      end
      if (cmd.probe_start) begin
        cnt_r <= '0;
      end else if (cmd.probe_next) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Memory write port: zero during clearing, the request's key on a put.
  assign wr_en  = cmd.clr_step | cmd.write_slot;
  assign wr_key = cmd.clr_step ? '0 : key_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[ptr_r] <= wr_key;
    end
    if (cmd.write_slot) begin
      val_mem[ptr_r] <= val_r;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= val_mem[rd_addr];
  end

  // Status towards the controller.
  assign stat.key_zero   = (key_in == '0);
  assign stat.mod_last   = (step_r == STEP_W'(HASH_STEPS - 1));
  assign stat.clr_last   = (ptr_r == LAST_IDX);
  assign stat.slot_hit   = (rd_key_r == '0) || (rd_key_r == key_r);
  assign stat.last_probe = (cnt_r == LAST_IDX);
  assign stat.is_put     = (func_r == FUNC_PUT);

  // Result word register.
  assign found_nxt = (cmd.fin_status == ST_OK) && (func_r == FUNC_GET) &&
                     (rd_key_r == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r.found      <= found_nxt;
      out_data_r.read_value <= found_nxt ? rd_val_r : '0;
      out_data_r.status     <= cmd.fin_status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing key/value table with linear probing and no deletion.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. Each request
// gives exactly one result word, shown for one cycle with out_valid; the
// receiver cannot hold it off. A zero key is answered in the cycle after it
// is taken. Any other request visits P slots, P from 1 to TABLE_SIZE: the
// 32-bit hash is first reduced to the home slot by a reciprocal
// multiplication, the memory read is then started, and the probe walk
// checks one slot a cycle through the single read port of the key memory.
// busy is low again in the cycle the result is shown. After reset the key
// memory is cleared one slot a cycle, so busy stays high until every slot
// is clear, before the first request.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = 1024,
  parameter int KEY_WIDTH  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lpht_pkg::lpht_in_t  in_data,
  output logic                out_valid,
  output lpht_pkg::lpht_out_t out_data
);
  import lpht_pkg::*;

  lpht_cmd_t  cmd;
  lpht_stat_t stat;

  // Sequencer.
  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Memories, hash reduction and result register.
  lpht_datapath #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // The block is free again whenever a result word is shown.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word shown while busy");

  // A zero key is answered in the next cycle with the zero key status.
  a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && stat.key_zero) |=>
      (out_valid && (out_data.status == ST_ZERO_KEY) && !out_data.found))
    else $error("zero key not answered at once");

  // A real key needs the hash reduction, so it keeps the block busy.
  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !stat.key_zero) |=> (busy && !out_valid))
    else $error("request with a key did not start a probe walk");

  // A key that was found is never reported with an error status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found) |-> (out_data.status == ST_OK))
    else $error("found flag with error status");

endmodule
